### hdl/assert_macros.svh
// Assertion macros used by the checker file of this block.
// Depends on clk_i and rst_ni being visible where a macro is used.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

`define MCD_ASSERT_IMP(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |-> (cons)) \
    else $error(msg);

`define MCD_ASSERT_NXT(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |=> (cons)) \
    else $error(msg);

`endif

### hdl/mcd_pkg.sv
// Package for the MTI canceller and Doppler DFT block: types, widths and the
// elaboration-time twiddle generator. No dependencies.
package mcd_pkg;

  localparam int DoppPointsDef = 64;
  localparam int MaxPulsesDef  = 64;
  localparam int D_W   = 17;
  localparam int TW_W  = 16;
  localparam int ACC_W = 40;

  localparam logic REG_CANCEL_LAG  = 1'b0;
  localparam logic REG_PULSE_COUNT = 1'b1;

  localparam logic [63:0] Q60_ONE     = 64'h1000_0000_0000_0000;
  localparam logic [63:0] HALF_PI_Q60 = 64'h1921_FB54_442D_1846;

  typedef logic signed [TW_W-1:0] tw_t;

  typedef struct packed {
    logic                  valid;
    logic signed [D_W-1:0] re;
    logic signed [D_W-1:0] im;
  } d_t;

  typedef struct packed {
    logic signed [ACC_W-1:0] re;
    logic signed [ACC_W-1:0] im;
  } acc_t;

  function automatic logic [63:0] mulq(logic [63:0] a, logic [63:0] b);
    logic [127:0] p;
    p = a * b;
    return p[123:60];
  endfunction

  function automatic logic [15:0] to_q15(longint v);
    logic [63:0] mag;
    longint      r;
    mag = (v < 0) ? 64'(-v) : 64'(v);
    r = longint'((mag + 64'h0000_1000_0000_0000) >> 45);
    if (v < 0) r = -r;
    if (r > 32767) r = 32767;
    if (r < -32768) r = -32768;
    return r[15:0];
  endfunction

  // Returns the imaginary part in the upper half and the real part in the lower.
  function automatic logic [31:0] tw_pair(logic [63:0] x, logic [1:0] quad);
    logic [63:0] x2;
    logic [63:0] term;
    longint      c;
    longint      s;
    longint      cs;
    longint      sn;
    logic        neg;
    x2   = mulq(x, x);
    term = Q60_ONE;
    c    = longint'(Q60_ONE);
    s    = longint'(x);
    neg  = 1'b1;
    for (int n = 2; n <= 40; n += 2) begin
      term = mulq(term, x2) / 64'(n * (n - 1));
      c    = neg ? c - longint'(term) : c + longint'(term);
      neg  = !neg;
    end
    term = x;
    neg  = 1'b1;
    for (int n = 3; n <= 41; n += 2) begin
      term = mulq(term, x2) / 64'(n * (n - 1));
      s    = neg ? s - longint'(term) : s + longint'(term);
      neg  = !neg;
    end
    unique case (quad)
      2'd0: begin cs = c;  sn = s;  end
      2'd1: begin cs = -s; sn = c;  end
      2'd2: begin cs = -c; sn = -s; end
      default: begin cs = s; sn = -c; end
    endcase
    return {to_q15(-sn), to_q15(cs)};
  endfunction

endpackage

### hdl/mcd_cell.sv
// One Doppler bin cell: rotates the passing difference by its own twiddle,
// accumulates it and shifts its sum towards the output. Depends on mcd_pkg.
module mcd_cell #(
  parameter int Points = mcd_pkg::DoppPointsDef,
  parameter int Bin    = 0
) (
  input  logic                clk_i,
  input  logic                rst_ni,
  input  logic                clear_i,
  input  logic                shift_i,
  input  mcd_pkg::tw_t        tw_re_i [Points],
  input  mcd_pkg::tw_t        tw_im_i [Points],
  input  mcd_pkg::d_t         d_i,
  output mcd_pkg::d_t         d_o,
  input  mcd_pkg::acc_t       acc_i,
  output mcd_pkg::acc_t       acc_o
);
  import mcd_pkg::*;

  localparam int PW = $clog2(Points);
  localparam logic [PW:0] STEP = (PW + 1)'(Bin);
  localparam logic [PW:0] NPTS = (PW + 1)'(Points);

  logic                    pass_v_q;
  logic signed [D_W-1:0]   pass_re_q;
  logic signed [D_W-1:0]   pass_im_q;
  logic                    pv_q;
  logic [PW-1:0]           phase_q;
  logic [PW:0]             phase_sum;
  logic [PW-1:0]           phase_d;
  logic signed [33:0]      prod_re_d;
  logic signed [33:0]      prod_im_d;
  logic signed [33:0]      pr_re_q;
  logic signed [33:0]      pr_im_q;
  logic signed [ACC_W-1:0] pr_re_x;
  logic signed [ACC_W-1:0] pr_im_x;
  acc_t                    acc_q;

  always_comb begin
    phase_sum = {1'b0, phase_q} + STEP;
    phase_d   = (phase_sum >= NPTS) ? PW'(phase_sum - NPTS) : phase_sum[PW-1:0];
    prod_re_d = d_i.re * tw_re_i[phase_q] - d_i.im * tw_im_i[phase_q];
    prod_im_d = d_i.re * tw_im_i[phase_q] + d_i.im * tw_re_i[phase_q];
    pr_re_x   = pr_re_q;
    pr_im_x   = pr_im_q;
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      pass_v_q <= 1'b0;
      pv_q     <= 1'b0;
      phase_q  <= '0;
    end else if (clear_i) begin
      pass_v_q <= 1'b0;
      pv_q     <= 1'b0;
      phase_q  <= '0;
    end else begin
      pass_v_q <= d_i.valid;
      pv_q     <= d_i.valid;
      if (d_i.valid) begin
        phase_q <= phase_d;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    pass_re_q <= d_i.re;
    pass_im_q <= d_i.im;
    pr_re_q   <= prod_re_d;
    pr_im_q   <= prod_im_d;
    if (clear_i) begin
      acc_q <= '0;
    end else if (shift_i) begin
      acc_q <= acc_i;
    end else if (pv_q) begin
      acc_q.re <= acc_q.re + pr_re_x;
      acc_q.im <= acc_q.im + pr_im_x;
    end
  end

  assign d_o   = '{valid: pass_v_q, re: pass_re_q, im: pass_im_q};
  assign acc_o = acc_q;

endmodule

### hdl/mti_canceller_doppler_dft_core.sv
// Top level of the MTI pulse canceller with zero-padded Doppler DFT.
// Depends on mcd_pkg and mcd_cell.
// Samples are taken one per cycle while busy_o is low. After the last pulse of a
// range bin the block reads len differences into a row of DOPPLER_POINTS cells, waits
// for the row to settle and then issues one bin a cycle. The receiver cannot stall.
// Reset sets cancel_lag to 1 and pulse_count to 64.
module mti_canceller_doppler_dft_core #(
  parameter int DOPPLER_POINTS = mcd_pkg::DoppPointsDef,
  parameter int MAX_PULSES     = mcd_pkg::MaxPulsesDef
) (
  input  logic               clk_i,
  input  logic               rst_ni,
  input  logic               start_i,
  output logic               busy_o,
  input  logic signed [15:0] sample_re_i,
  input  logic signed [15:0] sample_im_i,
  output logic               doppler_valid_o,
  output logic signed [23:0] doppler_re_o,
  output logic signed [23:0] doppler_im_o,
  output logic [5:0]         doppler_bin_o,
  output logic               last_bin_o,
  input  logic               cfg_valid_i,
  output logic               cfg_ready_o,
  input  logic               cfg_index_i,
  input  logic [6:0]         cfg_data_i
);
  import mcd_pkg::*;

  localparam int AW = (MAX_PULSES > 1) ? $clog2(MAX_PULSES) : 1;
  localparam int PW = $clog2(DOPPLER_POINTS);
  localparam int WW = $clog2(DOPPLER_POINTS + 5);

  typedef enum logic [1:0] {ST_LOAD, ST_FEED, ST_DRAIN, ST_OUT} state_e;

  state_e             state_q;
  logic [3:0]         lag_q;
  logic [6:0]         pcount_q;
  logic [6:0]         p_eff;
  logic [6:0]         len_d;
  logic [6:0]         cnt_q;
  logic [6:0]         len_q;
  logic [6:0]         r_q;
  logic [6:0]         rb;
  logic [WW-1:0]      wait_q;
  logic [PW-1:0]      k_q;
  logic               rd_v_d;
  logic               rd_v_q;
  logic [31:0]        rd_a_q;
  logic [31:0]        rd_b_q;
  logic [31:0]        mem_q [MAX_PULSES];
  d_t                 inj_q;
  logic signed [D_W-1:0] diff_re;
  logic signed [D_W-1:0] diff_im;
  logic               accept;
  logic               clear;
  logic               shift;
  logic [23:0]        out_re_d;
  logic [23:0]        out_im_d;
  tw_t                tw_re [DOPPLER_POINTS];
  tw_t                tw_im [DOPPLER_POINTS];
  d_t                 d_chain [DOPPLER_POINTS+1];
  acc_t               acc_chain [DOPPLER_POINTS+1];

  function automatic logic [23:0] scale24(logic signed [ACC_W-1:0] s);
    logic signed [ACC_W:0]    t;
    logic signed [ACC_W-15:0] q;
    t = s + 41'sd16384;
    q = t[ACC_W:15];
    if (q > 26'sd8388607) return 24'h7F_FFFF;
    if (q < -26'sd8388608) return 24'h80_0000;
    return q[23:0];
  endfunction

  for (genvar m = 0; m < DOPPLER_POINTS; m++) begin : g_tw
    localparam int          QI  = (4 * m) / DOPPLER_POINTS;
    localparam logic [63:0] REM = 64'((4 * m) % DOPPLER_POINTS);
    localparam logic [63:0] XM  = (HALF_PI_Q60 / DOPPLER_POINTS) * REM +
                                  ((HALF_PI_Q60 % DOPPLER_POINTS) * REM) / DOPPLER_POINTS;
    localparam logic [31:0] TWP = tw_pair(XM, 2'(QI));
    assign tw_re[m] = TWP[15:0];
    assign tw_im[m] = TWP[31:16];
  end

  always_comb begin
    if (pcount_q < 7'd2) begin
      p_eff = 7'd2;
    end else if (pcount_q > 7'(MAX_PULSES)) begin
      p_eff = 7'(MAX_PULSES);
    end else begin
      p_eff = pcount_q;
    end
    len_d = ({3'b0, lag_q} < p_eff) ? p_eff - {3'b0, lag_q} : 7'd0;
    if (len_d > 7'(DOPPLER_POINTS)) len_d = 7'(DOPPLER_POINTS);
    rb      = r_q + {3'b0, lag_q};
    rd_v_d  = (state_q == ST_FEED) && (r_q < len_q);
    accept  = start_i && (state_q == ST_LOAD);
    clear   = (state_q == ST_LOAD);
    shift   = (state_q == ST_OUT);
    diff_re = $signed(rd_a_q[15:0]) - $signed(rd_b_q[15:0]);
    diff_im = $signed(rd_a_q[31:16]) - $signed(rd_b_q[31:16]);
    out_re_d = scale24(acc_chain[0].re);
    out_im_d = scale24(acc_chain[0].im);
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      lag_q    <= 4'd1;
      pcount_q <= 7'd64;
    end else if (cfg_valid_i) begin
      unique case (cfg_index_i)
        REG_CANCEL_LAG:  lag_q    <= cfg_data_i[3:0];
        REG_PULSE_COUNT: pcount_q <= cfg_data_i;
        default: ;
      endcase
    end
  end

  always_ff @(posedge clk_i) begin
    if (accept) begin
      mem_q[cnt_q[AW-1:0]] <= {sample_im_i, sample_re_i};
    end
    rd_a_q <= mem_q[r_q[AW-1:0]];
    rd_b_q <= mem_q[rb[AW-1:0]];
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      rd_v_q <= 1'b0;
      inj_q  <= '0;
    end else begin
      rd_v_q      <= rd_v_d;
      inj_q.valid <= rd_v_q;
      inj_q.re    <= diff_re;
      inj_q.im    <= diff_im;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q         <= ST_LOAD;
      cnt_q           <= '0;
      len_q           <= '0;
      r_q             <= '0;
      wait_q          <= '0;
      k_q             <= '0;
      doppler_valid_o <= 1'b0;
      doppler_re_o    <= '0;
      doppler_im_o    <= '0;
      doppler_bin_o   <= '0;
      last_bin_o      <= 1'b0;
    end else begin
      doppler_valid_o <= 1'b0;
      unique case (state_q)
        ST_LOAD: begin
          if (start_i) begin
            if (cnt_q + 7'd1 < p_eff) begin
              cnt_q <= cnt_q + 7'd1;
            end else begin
              cnt_q   <= '0;
              len_q   <= len_d;
              r_q     <= '0;
              state_q <= ST_FEED;
            end
          end
        end
        ST_FEED: begin
          if (r_q < len_q) begin
            r_q <= r_q + 7'd1;
          end else begin
            wait_q  <= WW'(DOPPLER_POINTS + 4);
            state_q <= ST_DRAIN;
          end
        end
        ST_DRAIN: begin
          if (wait_q == '0) begin
            k_q     <= '0;
            state_q <= ST_OUT;
          end else begin
            wait_q <= wait_q - WW'(1);
          end
        end
        ST_OUT: begin
          doppler_valid_o <= 1'b1;
          doppler_re_o    <= out_re_d;
          doppler_im_o    <= out_im_d;
          doppler_bin_o   <= 6'(k_q);
          last_bin_o      <= (k_q == PW'(DOPPLER_POINTS - 1));
          if (k_q == PW'(DOPPLER_POINTS - 1)) begin
            state_q <= ST_LOAD;
          end else begin
            k_q <= k_q + PW'(1);
          end
        end
        default: state_q <= ST_LOAD;
      endcase
    end
  end

  assign d_chain[0]                 = inj_q;
  assign acc_chain[DOPPLER_POINTS]  = '0;

  for (genvar k = 0; k < DOPPLER_POINTS; k++) begin : g_cell
    mcd_cell #(
      .Points (DOPPLER_POINTS),
      .Bin    (k)
    ) u_cell (
      .clk_i   (clk_i),
      .rst_ni  (rst_ni),
      .clear_i (clear),
      .shift_i (shift),
      .tw_re_i (tw_re),
      .tw_im_i (tw_im),
      .d_i     (d_chain[k]),
      .d_o     (d_chain[k+1]),
      .acc_i   (acc_chain[k+1]),
      .acc_o   (acc_chain[k])
    );
  end

  assign busy_o      = (state_q != ST_LOAD);
  assign cfg_ready_o = 1'b1;

endmodule

### hdl/mcd_sva.sv
// Port-level checker for the MTI canceller and Doppler DFT block, bound to the
// top level. Depends on assert_macros.svh.
`include "assert_macros.svh"

module mcd_sva (
  input logic               clk_i,
  input logic               rst_ni,
  input logic               start_i,
  input logic               busy_o,
  input logic               doppler_valid_o,
  input logic [5:0]         doppler_bin_o,
  input logic               last_bin_o
);

  `MCD_ASSERT_NXT(a_gap_after_last, doppler_valid_o && last_bin_o, !doppler_valid_o, "beat after last bin")

  `MCD_ASSERT_NXT(a_bins_in_order, doppler_valid_o && !last_bin_o, doppler_valid_o && (doppler_bin_o == 6'($past(doppler_bin_o) + 6'd1)), "bins out of order")

  `MCD_ASSERT_IMP(a_busy_while_out, doppler_valid_o && !last_bin_o, busy_o, "result beat while idle")

  `MCD_ASSERT_IMP(a_quiet_on_start, $rose(busy_o), !doppler_valid_o, "result beat as bin starts")

endmodule

bind mti_canceller_doppler_dft_core mcd_sva u_mcd_sva (.*);

### verif/mti_canceller_doppler_dft_core_tb.sv
// Self-checking testbench for mti_canceller_doppler_dft_core: canceller plus Doppler DFT.
// Depends on mcd_pkg and the block's RTL. It predicts every Doppler bin in SystemVerilog
// and checks each strobed result against it in order.
`timescale 1ns / 100ps

module mti_canceller_doppler_dft_core_tb;
  import mcd_pkg::*;

  typedef enum logic [1:0] {OP_SAMPLE, OP_CFG, OP_DRAIN} op_e;

  typedef struct {
    op_e         op;
    logic [15:0] re;
    logic [15:0] im;
    logic        idx;
    logic [6:0]  data;
    int          gap;
  } beat_t;

  typedef struct {
    logic [23:0] re;
    logic [23:0] im;
    logic [5:0]  bin;
    logic        last;
  } bin_t;

  localparam int NPTS  = 64;
  localparam int LIMIT = 600000;
  localparam int QUIET = 8;

  logic              clk_i = 1'b0;
  logic              rst_ni = 1'b0;
  logic              start_i = 1'b0;
  logic              busy_o;
  logic signed [15:0] sample_re_i = '0;
  logic signed [15:0] sample_im_i = '0;
  logic              doppler_valid_o;
  logic signed [23:0] doppler_re_o;
  logic signed [23:0] doppler_im_o;
  logic [5:0]        doppler_bin_o;
  logic              last_bin_o;
  logic              cfg_valid_i = 1'b0;
  logic              cfg_ready_o;
  logic              cfg_index_i = 1'b0;
  logic [6:0]        cfg_data_i = '0;

  mti_canceller_doppler_dft_core uut (.*);

  always begin
    #2 clk_i = 1'b1;
    #2 clk_i = 1'b0;
  end

  beat_t       pending[$];
  bin_t        doppler_exp[$];
  int          errors = 0;
  int          quiet = 0;
  int          cycles = 0;
  logic        active = 1'b0;
  beat_t       cur;
  int          wait_cnt = 0;
  int          tw_re[NPTS];
  int          tw_im[NPTS];
  logic [31:0] pulse_mem[64];
  int          pulse_idx = 0;
  int          lag_reg = 1;
  int          count_reg = 64;

  function automatic int round_q15(real v);
    int r;
    r = (v >= 0.0) ? $rtoi(v + 0.5) : -$rtoi(-v + 0.5);
    if (r > 32767) r = 32767;
    if (r < -32768) r = -32768;
    return r;
  endfunction

  function automatic logic [23:0] scale_bin(longint s);
    longint q;
    q = (s + 16384) >>> 15;
    if (q > 8388607) q = 8388607;
    if (q < -8388608) q = -8388608;
    return q[23:0];
  endfunction

  task automatic take_sample(logic [15:0] re, logic [15:0] im);
    int     p;
    int     len;
    int     dre[NPTS];
    int     dim[NPTS];
    longint sre;
    longint sim;
    int     m;
    bin_t   b;
    p = count_reg < 2 ? 2 : (count_reg > 64 ? 64 : count_reg);
    pulse_mem[pulse_idx % 64] = {im, re};
    if (pulse_idx + 1 < p) begin
      pulse_idx++;
      return;
    end
    pulse_idx = 0;
    len = lag_reg < p ? p - lag_reg : 0;
    if (len > NPTS) len = NPTS;
    for (int r = 0; r < len; r++) begin
      dre[r] = int'($signed(pulse_mem[r][15:0])) -
               int'($signed(pulse_mem[(r + lag_reg) % 64][15:0]));
      dim[r] = int'($signed(pulse_mem[r][31:16])) -
               int'($signed(pulse_mem[(r + lag_reg) % 64][31:16]));
    end
    for (int k = 0; k < NPTS; k++) begin
      sre = 0;
      sim = 0;
      for (int r = 0; r < len; r++) begin
        m = (r * k) % NPTS;
        sre += longint'(dre[r]) * tw_re[m] - longint'(dim[r]) * tw_im[m];
        sim += longint'(dre[r]) * tw_im[m] + longint'(dim[r]) * tw_re[m];
      end
      b.re = scale_bin(sre);
      b.im = scale_bin(sim);
      b.bin = k[5:0];
      b.last = (k == NPTS - 1);
      doppler_exp.push_back(b);
    end
  endtask

  function automatic logic [15:0] pick_value();
    case ($urandom_range(0, 7))
      0: return 16'h7FFF;
      1: return 16'h8000;
      2: return 16'h0000;
      default: return 16'($urandom);
    endcase
  endfunction

  function automatic beat_t mk_sample(logic [15:0] re, logic [15:0] im, int gap);
    beat_t b;
    b.op = OP_SAMPLE;
    b.re = re;
    b.im = im;
    b.idx = 1'b0;
    b.data = '0;
    b.gap = gap;
    return b;
  endfunction

  function automatic beat_t mk_cfg(logic idx, logic [6:0] data, int gap);
    beat_t b;
    b = mk_sample('0, '0, gap);
    b.op = OP_CFG;
    b.idx = idx;
    b.data = data;
    return b;
  endfunction

  always @(posedge clk_i) begin
    cycles <= cycles + 1;
    if (cycles == LIMIT) begin
      $display("FAIL");
      $finish;
    end
  end

  always @(posedge clk_i or negedge rst_ni) begin
    logic n_start;
    logic n_cfg;
    logic idle;
    if (!rst_ni) begin
      start_i <= 1'b0;
      cfg_valid_i <= 1'b0;
      active = 1'b0;
    end else begin
      n_start = start_i;
      n_cfg = cfg_valid_i;
      quiet <= doppler_valid_o ? 0 : quiet + 1;
      if (start_i && !busy_o) begin
        take_sample(sample_re_i, sample_im_i);
        n_start = 1'b0;
        active = 1'b0;
      end
      if (cfg_valid_i && cfg_ready_o) begin
        if (cfg_index_i == REG_CANCEL_LAG) lag_reg = cfg_data_i[3:0];
        else count_reg = cfg_data_i;
        n_cfg = 1'b0;
        active = 1'b0;
      end
      if (!active && pending.size() > 0) begin
        cur = pending.pop_front();
        wait_cnt = cur.gap;
        active = 1'b1;
      end
      idle = doppler_exp.size() == 0 && quiet >= QUIET && !busy_o && !doppler_valid_o;
      if (active && !n_start && !n_cfg) begin
        if (wait_cnt > 0) begin
          wait_cnt--;
        end else if (cur.op == OP_SAMPLE) begin
          n_start = 1'b1;
          sample_re_i <= cur.re;
          sample_im_i <= cur.im;
        end else if (idle) begin
          if (cur.op == OP_CFG) begin
            n_cfg = 1'b1;
            cfg_index_i <= cur.idx;
            cfg_data_i <= cur.data;
          end else begin
            active = 1'b0;
          end
        end
      end
      start_i <= n_start;
      cfg_valid_i <= n_cfg;
    end
  end

  always @(posedge clk_i) begin
    bin_t e;
    if (rst_ni && doppler_valid_o) begin
      if (doppler_exp.size() == 0) begin
        $display("%0t unexpected bin %0d re %0d im %0d", $realtime, doppler_bin_o,
                 doppler_re_o, doppler_im_o);
        errors++;
      end else begin
        e = doppler_exp.pop_front();
        if (doppler_re_o !== e.re) begin
          $display("%0t re: expected %0d actual %0d", $realtime, $signed(e.re), doppler_re_o);
          errors++;
        end
        if (doppler_im_o !== e.im) begin
          $display("%0t im: expected %0d actual %0d", $realtime, $signed(e.im), doppler_im_o);
          errors++;
        end
        if (doppler_bin_o !== e.bin) begin
          $display("%0t bin: expected %0d actual %0d", $realtime, e.bin, doppler_bin_o);
          errors++;
        end
        if (last_bin_o !== e.last) begin
          $display("%0t last: expected %0d actual %0d", $realtime, e.last, last_bin_o);
          errors++;
        end
      end
    end
  end

  initial begin
    int n_items;
    int eff;
    int nb;
    int gmax;
    int cnt;
    for (int m = 0; m < NPTS; m++) begin
      tw_re[m] = round_q15(32768.0 * $cos(2.0 * 3.14159265358979323846 * m / NPTS));
      tw_im[m] = round_q15(-32768.0 * $sin(2.0 * 3.14159265358979323846 * m / NPTS));
    end
    foreach (pulse_mem[i]) pulse_mem[i] = '0;

    // Extremes with a short bin, lag of zero, lag not below the count, counts out of range.
    pending.push_back(mk_cfg(REG_PULSE_COUNT, 7'd4, 0));
    pending.push_back(mk_sample(16'h7FFF, 16'h8000, 0));
    pending.push_back(mk_sample(16'h8000, 16'h7FFF, 0));
    pending.push_back(mk_sample(16'h7FFF, 16'h8000, 3));
    pending.push_back(mk_sample(16'hFFFF, 16'h0000, 0));
    pending.push_back(mk_cfg(REG_CANCEL_LAG, 7'd0, 0));
    pending.push_back(mk_cfg(REG_PULSE_COUNT, 7'd0, 0));
    pending.push_back(mk_sample(16'h1234, 16'hABCD, 0));
    pending.push_back(mk_sample(16'h8000, 16'h7FFF, 0));
    pending.push_back(mk_cfg(REG_CANCEL_LAG, 7'd15, 0));
    pending.push_back(mk_cfg(REG_PULSE_COUNT, 7'd1, 0));
    pending.push_back(mk_sample(16'h7FFF, 16'h7FFF, 0));
    pending.push_back(mk_sample(16'h8000, 16'h8000, 0));
    pending.push_back(mk_cfg(REG_CANCEL_LAG, 7'd2, 0));
    pending.push_back(mk_cfg(REG_PULSE_COUNT, 7'd8, 0));
    for (int i = 0; i < 3; i++) pending.push_back(mk_sample(pick_value(), pick_value(), 0));
    pending.push_back(mk_cfg(REG_PULSE_COUNT, 7'd3, 0));
    pending.push_back(mk_sample(16'h5555, 16'hAAAA, 1));
    n_items = 12;

    while (n_items < 450) begin
      gmax = $urandom_range(0, 2) == 0 ? 0 : 19;
      if ($urandom_range(0, 3) == 0) begin
        pending.push_back(mk_cfg(REG_CANCEL_LAG,
                                 $urandom_range(0, 4) == 0 ? 7'd15 : 7'($urandom_range(0, 5)),
                                 $urandom_range(0, gmax)));
      end
      case ($urandom_range(0, 19))
        0: cnt = 64;
        1: cnt = 127;
        2: cnt = $urandom_range(0, 1);
        3: cnt = $urandom_range(65, 126);
        default: cnt = $urandom_range(2, 10);
      endcase
      pending.push_back(mk_cfg(REG_PULSE_COUNT, 7'(cnt), $urandom_range(0, gmax)));
      eff = cnt < 2 ? 2 : (cnt > 64 ? 64 : cnt);
      nb = eff > 16 ? 1 : $urandom_range(1, 3);
      if ($urandom_range(0, 9) == 0) begin
        for (int i = 0; i < eff; i++)
          pending.push_back(mk_sample(i[0] ? 16'h8000 : 16'h7FFF, i[0] ? 16'h7FFF : 16'h8000,
                                      $urandom_range(0, gmax)));
        n_items += eff;
      end
      for (int i = 0; i < eff * nb; i++)
        pending.push_back(mk_sample(pick_value(), pick_value(), $urandom_range(0, gmax)));
      n_items += eff * nb;
      if ($urandom_range(0, 7) == 0) begin
        nb = $urandom_range(1, eff - 1);
        for (int i = 0; i < nb; i++)
          pending.push_back(mk_sample(pick_value(), pick_value(), $urandom_range(0, gmax)));
        n_items += nb;
      end
      if ($urandom_range(0, 5) == 0) pending.push_back(mk_cfg(REG_CANCEL_LAG, 7'd0, 0));
      if ($urandom_range(0, 9) == 0) pending.push_back(mk_cfg(REG_PULSE_COUNT, 7'd0, 0));
      if ($urandom_range(0, 9) == 0) begin
        pending.push_back(mk_cfg(REG_PULSE_COUNT, 7'd0, 0));
        pending[$].op = OP_DRAIN;
      end
    end

    repeat (7) @(posedge clk_i);
    rst_ni <= 1'b1;
    wait (pending.size() == 0 && !active);
    wait (doppler_exp.size() == 0);
    repeat (300) @(posedge clk_i);
    if (errors == 0 && doppler_exp.size() == 0) begin
      $display("PASS");
    end else begin
      $display("FAIL");
    end
    $finish;
  end

endmodule
